// ===== hdl/msfbb_pkg.sv =====
// Shared types and codes of the multi-source frame batch buffer.
package msfbb_pkg;

   localparam logic [2:0] FUNC_STORE_LOCAL    = 3'd0;
   localparam logic [2:0] FUNC_STORE_WIRELESS = 3'd1;
   localparam logic [2:0] FUNC_STATUS         = 3'd2;
   localparam logic [2:0] FUNC_MAKE_BATCH     = 3'd3;
   localparam logic [2:0] FUNC_READ_ENTRY     = 3'd4;
   localparam logic [2:0] FUNC_MARK_UPLOADED  = 3'd5;
   localparam logic [2:0] FUNC_CLEAR_BATCH    = 3'd6;
   localparam logic [2:0] FUNC_READ_DROPS     = 3'd7;

   localparam int unsigned CSR_INDEX_W = 1;
   localparam logic [CSR_INDEX_W-1:0] CSR_ACTIVE_TIMEOUT   = 1'd0;
   localparam logic [CSR_INDEX_W-1:0] CSR_STATUS_INTERVAL  = 1'd1;

   localparam logic [31:0] ACTIVE_TIMEOUT_RESET  = 32'd3000;
   localparam logic [31:0] STATUS_INTERVAL_RESET = 32'd1000;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_EXEC,
      ST_OUT
   } state_type;

   typedef struct packed {
      logic latch;
      logic exec;
   } cmd_type;

   typedef struct packed {
      logic skip;
   } status_type;

endpackage

// ===== hdl/msfbb_ctrl.sv =====
// Controller state machine of the frame batch buffer.
module msfbb_ctrl (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_valid,
   output logic                  req_stall,
   output logic                  rsp_valid,
   input  logic                  rsp_stall,
   input  msfbb_pkg::status_type status,
   output msfbb_pkg::cmd_type    cmd
);

   msfbb_pkg::state_type state_ff;
   msfbb_pkg::state_type state_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= msfbb_pkg::ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      state_in = state_ff;
      case (state_ff)
         msfbb_pkg::ST_IDLE: begin
            if (req_valid) state_in = msfbb_pkg::ST_EXEC;
         end
         msfbb_pkg::ST_EXEC: begin
            state_in = status.skip ? msfbb_pkg::ST_IDLE : msfbb_pkg::ST_OUT;
         end
         msfbb_pkg::ST_OUT: begin
            if (!rsp_stall) state_in = msfbb_pkg::ST_IDLE;
         end
         default: begin
            state_in = msfbb_pkg::ST_IDLE;
         end
      endcase
   end

   always_comb begin
      cmd.latch = 1'b0;
      cmd.exec  = 1'b0;
      req_stall = 1'b1;
      rsp_valid = 1'b0;
      case (state_ff)
         msfbb_pkg::ST_IDLE: begin
            req_stall = 1'b0;
            cmd.latch = req_valid;
         end
         msfbb_pkg::ST_EXEC: begin
            cmd.exec = 1'b1;
         end
         msfbb_pkg::ST_OUT: begin
            rsp_valid = 1'b1;
         end
         default: begin
            req_stall = 1'b1;
         end
      endcase
   end

endmodule

// ===== hdl/msfbb_datapath.sv =====
// Datapath of the frame batch buffer: frame memory, counters, timers and result registers.
module msfbb_datapath #(
   parameter int unsigned NODE_COUNT       = 4,
   parameter int unsigned SLOTS_PER_SOURCE = 32,
   parameter int unsigned FRAME_BITS       = 64
) (
   input  logic                                clock,
   input  logic                                reset,
   input  msfbb_pkg::cmd_type                  cmd,
   output msfbb_pkg::status_type               status,
   input  logic [2:0]                          req_func,
   input  logic [7:0]                          req_source_id,
   input  logic [4:0]                          req_entry_index,
   input  logic [63:0]                         req_frame_data,
   input  logic [31:0]                         req_now_ms,
   input  logic                                csr_write,
   input  logic [msfbb_pkg::CSR_INDEX_W-1:0]   csr_index,
   input  logic [31:0]                         csr_data,
   output logic                                rsp_op_ok,
   output logic                                rsp_batch_pending,
   output logic [5:0]                          rsp_entry_count,
   output logic                                rsp_entry_valid,
   output logic [63:0]                         rsp_frame_out,
   output logic [31:0]                         rsp_drop_count,
   output logic [7:0]                          rsp_active_mask
);

   localparam int unsigned SRC_COUNT = NODE_COUNT + 1;
   localparam int unsigned SRC_W     = $clog2(SRC_COUNT);
   localparam int unsigned SLOT_W    = (SLOTS_PER_SOURCE > 1) ? $clog2(SLOTS_PER_SOURCE) : 1;
   localparam int unsigned CNT_W     = $clog2(SLOTS_PER_SOURCE + 1);
   localparam int unsigned DEPTH     = 2 * SRC_COUNT * SLOTS_PER_SOURCE;
   localparam int unsigned ADDR_W    = $clog2(DEPTH);

   logic [2:0]            func_ff;
   logic [7:0]            src_ff;
   logic [4:0]            idx_ff;
   logic [FRAME_BITS-1:0] frame_ff;
   logic [31:0]           now_ff;

   logic [31:0] timeout_ff;
   logic [31:0] interval_ff;

   logic [CNT_W-1:0] rx_cnt_ff   [SRC_COUNT];
   logic [CNT_W-1:0] pend_cnt_ff [SRC_COUNT];
   logic [31:0]      drop_ff     [SRC_COUNT];
   logic [31:0]      seen_time_ff[NODE_COUNT];
   logic [NODE_COUNT-1:0] seen_ff;
   logic             pend_flag_ff;
   logic [31:0]      last_check_ff;
   logic             bank_ff;

   logic [FRAME_BITS-1:0] mem [DEPTH];
   logic [FRAME_BITS-1:0] rd_data_ff;

   logic        ok_ff, ok_in;
   logic [5:0]  cnt_ff, cnt_in;
   logic        valid_ff, valid_in;
   logic [31:0] drops_ff, drops_in;
   logic [7:0]  mask_ff, mask_in;

   logic                  src_ok;
   logic                  node_ok;
   logic [SRC_W-1:0]      src_sel;
   logic                  put_en;
   logic [SRC_W-1:0]      put_src;
   logic                  room;
   logic [31:0]           drop_next;
   logic [ADDR_W-1:0]     wr_addr;
   logic [ADDR_W-1:0]     rd_addr;
   logic                  idx_hit;
   logic                  rx_any;
   logic                  pend_other;
   logic [31:0]           check_diff;
   logic                  too_soon;
   logic [NODE_COUNT-1:0] node_mask;

   always_comb begin
      src_ok    = src_ff < 8'(SRC_COUNT);
      node_ok   = (src_ff != 8'd0) && (src_ff <= 8'(NODE_COUNT));
      src_sel   = src_ff[SRC_W-1:0];
      put_en    = (func_ff == msfbb_pkg::FUNC_STORE_LOCAL) ||
                  ((func_ff == msfbb_pkg::FUNC_STORE_WIRELESS) && node_ok);
      put_src   = (func_ff == msfbb_pkg::FUNC_STORE_LOCAL) ? '0 : src_sel;
      room      = rx_cnt_ff[put_src] < CNT_W'(SLOTS_PER_SOURCE);
      drop_next = drop_ff[put_src] + 32'd1;
      wr_addr   = ADDR_W'((32'(bank_ff) * SRC_COUNT + 32'(put_src)) * SLOTS_PER_SOURCE
                  + 32'(rx_cnt_ff[put_src][SLOT_W-1:0]));
      rd_addr   = ADDR_W'((32'(!bank_ff) * SRC_COUNT + 32'(src_sel)) * SLOTS_PER_SOURCE
                  + 32'(SLOT_W'(idx_ff)));
      idx_hit   = 32'(idx_ff) < 32'(pend_cnt_ff[src_sel]);
      rx_any     = 1'b0;
      pend_other = 1'b0;
      for (int s = 0; s < SRC_COUNT; s++) begin
         if (rx_cnt_ff[s] != '0) rx_any = 1'b1;
         if ((pend_cnt_ff[s] != '0) && (SRC_W'(s) != src_sel)) pend_other = 1'b1;
      end
      check_diff = now_ff - last_check_ff;
      too_soon   = check_diff < interval_ff;
      for (int i = 0; i < NODE_COUNT; i++) begin
         node_mask[i] = seen_ff[i] && ((now_ff - seen_time_ff[i]) <= timeout_ff);
      end
      status.skip = (func_ff == msfbb_pkg::FUNC_STATUS) && too_soon;
   end

   always_comb begin
      ok_in    = 1'b0;
      cnt_in   = '0;
      valid_in = 1'b0;
      drops_in = '0;
      mask_in  = '0;
      case (func_ff)
         msfbb_pkg::FUNC_STORE_LOCAL, msfbb_pkg::FUNC_STORE_WIRELESS: begin
            if (put_en) begin
               ok_in    = room;
               drops_in = room ? drop_ff[put_src] : drop_next;
            end
         end
         msfbb_pkg::FUNC_STATUS: begin
            ok_in   = 1'b1;
            mask_in = 8'(node_mask);
         end
         msfbb_pkg::FUNC_MAKE_BATCH: begin
            ok_in = pend_flag_ff || rx_any;
         end
         msfbb_pkg::FUNC_READ_ENTRY: begin
            if (src_ok) begin
               ok_in    = 1'b1;
               cnt_in   = 6'(pend_cnt_ff[src_sel]);
               valid_in = idx_hit;
            end
         end
         msfbb_pkg::FUNC_MARK_UPLOADED: begin
            ok_in = src_ok;
         end
         msfbb_pkg::FUNC_CLEAR_BATCH: begin
            ok_in = 1'b1;
         end
         msfbb_pkg::FUNC_READ_DROPS: begin
            if (src_ok) begin
               ok_in    = 1'b1;
               drops_in = drop_ff[src_sel];
            end
         end
         default: begin
            ok_in = 1'b0;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (cmd.latch) begin
         func_ff  <= req_func;
         src_ff   <= req_source_id;
         idx_ff   <= req_entry_index;
         frame_ff <= req_frame_data[FRAME_BITS-1:0];
         now_ff   <= req_now_ms;
      end
      if (cmd.exec) begin
         ok_ff    <= ok_in;
         cnt_ff   <= cnt_in;
         valid_ff <= valid_in;
         drops_ff <= drops_in;
         mask_ff  <= mask_in;
         rd_data_ff <= mem[rd_addr];
         if (put_en && room) mem[wr_addr] <= frame_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         timeout_ff  <= msfbb_pkg::ACTIVE_TIMEOUT_RESET;
         interval_ff <= msfbb_pkg::STATUS_INTERVAL_RESET;
      end else if (csr_write) begin
         if (csr_index == msfbb_pkg::CSR_ACTIVE_TIMEOUT) timeout_ff <= csr_data;
         if (csr_index == msfbb_pkg::CSR_STATUS_INTERVAL) interval_ff <= csr_data;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int s = 0; s < SRC_COUNT; s++) begin
            rx_cnt_ff[s]   <= '0;
            pend_cnt_ff[s] <= '0;
            drop_ff[s]     <= '0;
         end
         for (int i = 0; i < NODE_COUNT; i++) begin
            seen_time_ff[i] <= '0;
         end
         seen_ff       <= '0;
         pend_flag_ff  <= 1'b0;
         last_check_ff <= '0;
         bank_ff       <= 1'b0;
      end else if (cmd.exec) begin
         case (func_ff)
            msfbb_pkg::FUNC_STORE_LOCAL, msfbb_pkg::FUNC_STORE_WIRELESS: begin
               if (put_en) begin
                  if (room) rx_cnt_ff[put_src] <= rx_cnt_ff[put_src] + CNT_W'(1);
                  else drop_ff[put_src] <= drop_next;
               end
               if (func_ff == msfbb_pkg::FUNC_STORE_WIRELESS) begin
                  for (int i = 0; i < NODE_COUNT; i++) begin
                     if (src_ff == 8'(i + 1)) begin
                        seen_time_ff[i] <= now_ff;
                        seen_ff[i]      <= 1'b1;
                     end
                  end
               end
            end
            msfbb_pkg::FUNC_STATUS: begin
               if (!too_soon) last_check_ff <= now_ff;
            end
            msfbb_pkg::FUNC_MAKE_BATCH: begin
               if (!pend_flag_ff) begin
                  for (int s = 0; s < SRC_COUNT; s++) begin
                     pend_cnt_ff[s] <= rx_cnt_ff[s];
                     rx_cnt_ff[s]   <= '0;
                  end
                  bank_ff      <= ~bank_ff;
                  pend_flag_ff <= rx_any;
               end
            end
            msfbb_pkg::FUNC_MARK_UPLOADED: begin
               if (src_ok) begin
                  pend_cnt_ff[src_sel] <= '0;
                  pend_flag_ff         <= pend_other;
               end
            end
            msfbb_pkg::FUNC_CLEAR_BATCH: begin
               for (int s = 0; s < SRC_COUNT; s++) begin
                  pend_cnt_ff[s] <= '0;
               end
               pend_flag_ff <= 1'b0;
            end
            default: begin
               pend_flag_ff <= pend_flag_ff;
            end
         endcase
      end
   end

   assign rsp_op_ok         = ok_ff;
   assign rsp_batch_pending = pend_flag_ff;
   assign rsp_entry_count   = cnt_ff;
   assign rsp_entry_valid   = valid_ff;
   assign rsp_frame_out     = valid_ff ? 64'(rd_data_ff) : 64'd0;
   assign rsp_drop_count    = drops_ff;
   assign rsp_active_mask   = mask_ff;

endmodule

// ===== hdl/multi_source_frame_batch_buffer.sv =====
// Each accepted item passes the accept, execute and present steps of the controller in turn;
// the result is presented until it is taken, and a stall on the result side holds it there.
// The block takes no new item until the result of the last one has been taken.
// A status check that is too soon gives no result and frees the block after its execute step.
// Reset (synchronous) clears all source counts, flags, timers and restores register defaults;
// frame memory contents and result registers are not cleared.
module multi_source_frame_batch_buffer #(
   parameter int unsigned NODE_COUNT       = 4,
   parameter int unsigned SLOTS_PER_SOURCE = 32,
   parameter int unsigned FRAME_BITS       = 64
) (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              req_valid,
   output logic                              req_stall,
   input  logic [2:0]                        req_func,
   input  logic [7:0]                        req_source_id,
   input  logic [4:0]                        req_entry_index,
   input  logic [63:0]                       req_frame_data,
   input  logic [31:0]                       req_now_ms,
   output logic                              rsp_valid,
   input  logic                              rsp_stall,
   output logic                              rsp_op_ok,
   output logic                              rsp_batch_pending,
   output logic [5:0]                        rsp_entry_count,
   output logic                              rsp_entry_valid,
   output logic [63:0]                       rsp_frame_out,
   output logic [31:0]                       rsp_drop_count,
   output logic [7:0]                        rsp_active_mask,
   input  logic                              csr_write,
   input  logic [msfbb_pkg::CSR_INDEX_W-1:0] csr_index,
   input  logic [31:0]                       csr_data
);

   msfbb_pkg::cmd_type    cmd;
   msfbb_pkg::status_type status;

   msfbb_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .status    (status),
      .cmd       (cmd)
   );

   msfbb_datapath #(
      .NODE_COUNT       (NODE_COUNT),
      .SLOTS_PER_SOURCE (SLOTS_PER_SOURCE),
      .FRAME_BITS       (FRAME_BITS)
   ) u_datapath (
      .clock             (clock),
      .reset             (reset),
      .cmd               (cmd),
      .status            (status),
      .req_func          (req_func),
      .req_source_id     (req_source_id),
      .req_entry_index   (req_entry_index),
      .req_frame_data    (req_frame_data),
      .req_now_ms        (req_now_ms),
      .csr_write         (csr_write),
      .csr_index         (csr_index),
      .csr_data          (csr_data),
      .rsp_op_ok         (rsp_op_ok),
      .rsp_batch_pending (rsp_batch_pending),
      .rsp_entry_count   (rsp_entry_count),
      .rsp_entry_valid   (rsp_entry_valid),
      .rsp_frame_out     (rsp_frame_out),
      .rsp_drop_count    (rsp_drop_count),
      .rsp_active_mask   (rsp_active_mask)
   );

endmodule

// ===== hdl/msfbb_checker.sv =====
// Port-level assertion checker of the frame batch buffer, bound to the top level.
module msfbb_checker (
   input logic        clock,
   input logic        reset,
   input logic        req_valid,
   input logic        req_stall,
   input logic        rsp_valid,
   input logic        rsp_stall,
   input logic        rsp_op_ok,
   input logic        rsp_entry_valid,
   input logic [63:0] rsp_frame_out
);

   a_busy_while_result: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> req_stall)
      else $error("input taken while a result waits");

   a_busy_after_accept: assert property (@(posedge clock) disable iff (reset)
      (req_valid && !req_stall) |=> req_stall)
      else $error("second item taken while one is at work");

   a_result_once: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && !rsp_stall) |=> !rsp_valid)
      else $error("result repeated after it was taken");

   a_frame_zero: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && !rsp_entry_valid) |-> (rsp_frame_out == 64'd0))
      else $error("frame shown without a valid entry");

   a_valid_ok: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_entry_valid) |-> rsp_op_ok)
      else $error("valid entry on a failed operation");

endmodule

bind multi_source_frame_batch_buffer msfbb_checker u_msfbb_checker (
   .clock           (clock),
   .reset           (reset),
   .req_valid       (req_valid),
   .req_stall       (req_stall),
   .rsp_valid       (rsp_valid),
   .rsp_stall       (rsp_stall),
   .rsp_op_ok       (rsp_op_ok),
   .rsp_entry_valid (rsp_entry_valid),
   .rsp_frame_out   (rsp_frame_out)
);
